@@ sv/acbc_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-128 CBC decryption package
// Shared types, register map and byte-level functions for the decrypt core.
// ----------------------------------------------------------------------------
package acbc_pkg;

   localparam int Rounds = 10;
   localparam int Lanes = 4;

   typedef enum logic [1:0] {
      REG_KEY_HIGH = 2'd0,
      REG_KEY_LOW  = 2'd1,
      REG_IV_HIGH  = 2'd2,
      REG_IV_LOW   = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_EXPAND = 2'd1,
      ST_ROUND  = 2'd2,
      ST_OUT    = 2'd3
   } state_type;

   typedef struct packed {
      logic       load;
      logic       last;
      logic       run;
   } lane_ctrl_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
      logic [7:0] a2;
      logic [7:0] a4;
      logic [7:0] a8;
      a2 = xtime(a);
      a4 = xtime(a2);
      a8 = xtime(a4);
      gmul = (b[0] ? a : 8'h00) ^ (b[1] ? a2 : 8'h00) ^ (b[2] ? a4 : 8'h00)
           ^ (b[3] ? a8 : 8'h00);
   endfunction

   function automatic logic [7:0] gmul8(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc = acc ^ x;
         x = xtime(x);
      end
      gmul8 = acc;
   endfunction

   function automatic logic [7:0] ginv(input logic [7:0] a);
      logic [7:0] r;
      logic [7:0] p;
      r = 8'h01;
      p = a;
      for (int i = 0; i < 8; i++) begin
         if (i != 0) r = gmul8(r, p);
         p = gmul8(p, p);
      end
      ginv = r;
   endfunction

   function automatic logic [7:0] sbox(input logic [7:0] v);
      logic [7:0] i;
      i = ginv(v);
      sbox = i ^ {i[6:0], i[7]} ^ {i[5:0], i[7:6]} ^ {i[4:0], i[7:5]}
           ^ {i[3:0], i[7:4]} ^ 8'h63;
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] v);
      logic [7:0] b;
      b = {v[6:0], v[7]} ^ {v[4:0], v[7:5]} ^ {v[1:0], v[7:2]} ^ 8'h05;
      inv_sbox = ginv(b);
   endfunction

endpackage

@@ sv/acbc_lane.sv @@
// ----------------------------------------------------------------------------
// AES-128 CBC decryption column lane
// Holds one state column; applies the inverse round on bytes gathered by the
// merge network (already shifted) and the matching round key word.
// ----------------------------------------------------------------------------
module acbc_lane (
   input  logic                  clock,
   input  acbc_pkg::lane_ctrl_type ctrl,
   input  logic [31:0]           load_col,
   input  logic [31:0]           shifted_col,
   input  logic [31:0]           key_word,
   output logic [31:0]           col
);
   import acbc_pkg::*;

   logic [31:0] col_ff;
   logic [31:0] col_in;
   logic [7:0]  s [4];
   logic [7:0]  a [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s[i] = inv_sbox(shifted_col[31-8*i -: 8]) ^ key_word[31-8*i -: 8];
      end
      a[0] = gmul(s[0], 4'd14) ^ gmul(s[1], 4'd11) ^ gmul(s[2], 4'd13) ^ gmul(s[3], 4'd9);
      a[1] = gmul(s[0], 4'd9) ^ gmul(s[1], 4'd14) ^ gmul(s[2], 4'd11) ^ gmul(s[3], 4'd13);
      a[2] = gmul(s[0], 4'd13) ^ gmul(s[1], 4'd9) ^ gmul(s[2], 4'd14) ^ gmul(s[3], 4'd11);
      a[3] = gmul(s[0], 4'd11) ^ gmul(s[1], 4'd13) ^ gmul(s[2], 4'd9) ^ gmul(s[3], 4'd14);
      if (ctrl.load) begin
         col_in = load_col ^ key_word;
      end else if (ctrl.last) begin
         col_in = {s[0], s[1], s[2], s[3]};
      end else begin
         col_in = {a[0], a[1], a[2], a[3]};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.run) col_ff <= col_in;
   end

   assign col = col_ff;
endmodule

@@ sv/acbc_keyexp.sv @@
// ----------------------------------------------------------------------------
// AES-128 CBC decryption key schedule
// Expands the key one round key per cycle into a register file of eleven
// round keys.
// ----------------------------------------------------------------------------
module acbc_keyexp (
   input  logic         clock,
   input  logic         start,
   input  logic [3:0]   step,
   input  logic [127:0] key,
   input  logic [3:0]   rd_round,
   output logic [127:0] rd_key
);
   import acbc_pkg::*;

   logic [127:0] rk_ff [11];
   logic [7:0]   rcon_ff;
   logic [7:0]   rcon_in;
   logic [127:0] prev;
   logic [127:0] next;
   logic [31:0]  t;
   logic [31:0]  w [4];

   always_comb begin
      prev = rk_ff[step - 4'd1];
      t = {sbox(prev[23:16]) ^ rcon_ff, sbox(prev[15:8]), sbox(prev[7:0]),
           sbox(prev[31:24])};
      w[0] = prev[127:96] ^ t;
      w[1] = prev[95:64] ^ w[0];
      w[2] = prev[63:32] ^ w[1];
      w[3] = prev[31:0] ^ w[2];
      next = {w[0], w[1], w[2], w[3]};
      rcon_in = start ? 8'h01 : xtime(rcon_ff);
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rk_ff[0] <= key;
      end else if (step != 4'd0 && step <= 4'(Rounds)) begin
         rk_ff[step] <= next;
      end
      if (start || (step != 4'd0 && step <= 4'(Rounds))) begin
         rcon_ff <= (start ? 8'h01 : rcon_in);
      end
   end

   assign rd_key = rk_ff[rd_round];
endmodule

@@ sv/aes128_cbc_block_decrypt.sv @@
// ----------------------------------------------------------------------------
// AES-128 CBC block decryption
// A request is followed by key addition, ten rounds and chaining; the first
// request after reset or a key write runs the key expansion before them.
// One block is in flight at a time; a stalled result holds the core.
// Reset clears control state, the key-ready flag and the key and IV
// registers (to zero); the datapath registers are not reset.
// ----------------------------------------------------------------------------
module aes128_cbc_block_decrypt (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // cipher_high, cipher_low
   input  logic         req_tuser,  // first_block
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // plain_high, plain_low
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);
   import acbc_pkg::*;

   logic [63:0]  key_hi_ff, key_lo_ff, iv_hi_ff, iv_lo_ff;
   logic         keys_ready_ff;
   state_type    state_ff, state_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic [127:0] cipher_ff, prev_ff;
   logic         first_ff;
   logic [127:0] out_ff;
   logic         out_valid_ff;
   logic         wr;
   reg_index_type widx;
   logic [127:0] rd_key;
   logic [3:0]   rd_round;
   logic         kx_start;
   logic [3:0]   kx_step;
   lane_ctrl_type ctrl;
   logic [31:0]  col [Lanes];
   logic [31:0]  shc [Lanes];
   logic [127:0] state_v;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign widx = reg_index_type'(csr_paddr[4:3]);

   always_comb begin
      case (reg_index_type'(csr_paddr[4:3]))
         REG_KEY_HIGH: csr_prdata = key_hi_ff;
         REG_KEY_LOW:  csr_prdata = key_lo_ff;
         REG_IV_HIGH:  csr_prdata = iv_hi_ff;
         REG_IV_LOW:   csr_prdata = iv_lo_ff;
         default:      csr_prdata = 64'd0;
      endcase
   end

   acbc_keyexp u_keyexp (
      .clock(clock), .start(kx_start), .step(kx_step),
      .key({key_hi_ff, key_lo_ff}), .rd_round(rd_round), .rd_key(rd_key)
   );

   // Merge network: inverse shift rows across lanes.
   always_comb begin
      for (int c = 0; c < Lanes; c++) begin
         for (int r = 0; r < 4; r++) begin
            shc[c][31-8*r -: 8] = col[(c - r + 4) % 4][31-8*r -: 8];
         end
      end
      state_v = {col[0], col[1], col[2], col[3]};
   end

   for (genvar g = 0; g < Lanes; g++) begin : g_lane
      acbc_lane u_lane (
         .clock(clock), .ctrl(ctrl), .load_col(cipher_ff[127-32*g -: 32]),
         .shifted_col(shc[g]), .key_word(rd_key[127-32*g -: 32]), .col(col[g])
      );
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      kx_start = 1'b0;
      kx_step = 4'd0;
      rd_round = cnt_ff;
      ctrl = '{load: 1'b0, last: 1'b0, run: 1'b0};
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (!keys_ready_ff) begin
                  state_in = ST_EXPAND;
                  kx_start = 1'b1;
                  cnt_in = 4'd1;
               end else begin
                  state_in = ST_ROUND;
                  cnt_in = 4'(Rounds);
               end
            end
         end
         ST_EXPAND: begin
            kx_step = cnt_ff;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(Rounds)) begin
               state_in = ST_ROUND;
               cnt_in = 4'(Rounds);
            end
         end
         ST_ROUND: begin
            ctrl.run = 1'b1;
            ctrl.load = (cnt_ff == 4'(Rounds));
            ctrl.last = (cnt_ff == 4'd0);
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= 4'd0;
         keys_ready_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         key_hi_ff <= 64'd0;
         key_lo_ff <= 64'd0;
         iv_hi_ff <= 64'd0;
         iv_lo_ff <= 64'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         if (wr && (widx == REG_KEY_HIGH || widx == REG_KEY_LOW)) begin
            keys_ready_ff <= 1'b0;
         end else if (state_ff == ST_EXPAND && cnt_ff == 4'(Rounds)) begin
            keys_ready_ff <= 1'b1;
         end
         if (state_ff == ST_OUT && state_in == ST_IDLE) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tvalid && rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (wr) begin
            case (widx)
               REG_KEY_HIGH: key_hi_ff <= csr_pwdata;
               REG_KEY_LOW:  key_lo_ff <= csr_pwdata;
               REG_IV_HIGH:  iv_hi_ff <= csr_pwdata;
               REG_IV_LOW:   iv_lo_ff <= csr_pwdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cipher_ff <= {req_tdata[63:0], req_tdata[127:64]};
         first_ff <= req_tuser;
      end
      if (state_ff == ST_OUT && state_in == ST_IDLE) begin
         out_ff <= state_v ^ (first_ff ? {iv_hi_ff, iv_lo_ff} : prev_ff);
         prev_ff <= cipher_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {out_ff[63:0], out_ff[127:64]};

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> keys_ready_ff || wr)
      else $error("rounds started without expanded keys");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |=> (state_ff == ST_IDLE) || (state_ff == ST_OUT))
      else $error("result state left incorrectly");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXPAND) |-> !req_tready)
      else $error("request taken during key expansion");
endmodule
